FILE: src/mcod_pkg.sv
// Shared types, constants and codes for the matrix chain order block.
package mcod_pkg;

   localparam int DEF_MAX_MATRICES = 8;
   localparam int DEF_DIM_WIDTH    = 16;

   localparam int REQ_DATA_W   = 16;
   localparam int INDEX_WIDTH  = 4;
   localparam int SPLIT_WIDTH  = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int COST_WIDTH   = 52;
   localparam int RSP_DATA_W   = 2 * INDEX_WIDTH + COST_WIDTH + SPLIT_WIDTH;

   localparam logic [COST_WIDTH-1:0] COST_MAX = {COST_WIDTH{1'b1}};

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EXTRA = 2'd2;

   typedef enum logic {
      ALU_ADD,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      logic       en;
      alu_op_type op;
   } alu_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_ERR,
      S_DIAG,
      S_CELL,
      S_PI,
      S_PJ,
      S_FETCH,
      S_ADD1,
      S_MUL1,
      S_MUL2,
      S_ADD2,
      S_CMP,
      S_EM_RD,
      S_EM_LD
   } state_type;

endpackage

FILE: src/mcod_alu.sv
// Shared arithmetic unit: saturating cost adder and dimension multiplier.
module mcod_alu #(
   parameter int DIM_WIDTH = mcod_pkg::DEF_DIM_WIDTH
) (
   input  logic                            clock,
   input  mcod_pkg::alu_ctrl_type          ctrl,
   input  logic [mcod_pkg::COST_WIDTH-1:0] oper_a,
   input  logic [mcod_pkg::COST_WIDTH-1:0] oper_b,
   output logic [mcod_pkg::COST_WIDTH-1:0] result
);
   import mcod_pkg::*;

   logic [COST_WIDTH:0]      sum;
   logic [3*DIM_WIDTH-1:0]   product;
   logic [COST_WIDTH-1:0]    result_in;
   logic [COST_WIDTH-1:0]    result_ff;

   // The product of three dimensions never reaches the cost width, so only
   // the adder needs to saturate.
   assign sum     = {1'b0, oper_a} + {1'b0, oper_b};
   assign product = oper_a[2*DIM_WIDTH-1:0] * oper_b[DIM_WIDTH-1:0];

   always_comb begin
      case (ctrl.op)
         ALU_ADD: result_in = sum[COST_WIDTH] ? COST_MAX : sum[COST_WIDTH-1:0];
         ALU_MUL: result_in = COST_WIDTH'(product);
         default: result_in = sum[COST_WIDTH-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: src/matrix_chain_order_dp.sv
// Matrix chain order: loads a dimension list and emits the optimal cost and split table.
// Dimensions are taken only while idle. The last one starts a run: the diagonal, then
// for each cell (i,j) above it S_CELL, S_PI, S_PJ and, per split k, a step of S_FETCH,
// S_ADD1, S_MUL1, S_MUL2, S_ADD2 and S_CMP on the shared adder/multiplier, then
// n*(n+1)/2 results, each emitted when the output register is free. One chain per run.
// Reset is synchronous and clears the sequencer, dimension count, overflow flag and output valid only.
module matrix_chain_order_dp #(
   parameter int MAX_MATRICES = mcod_pkg::DEF_MAX_MATRICES,
   parameter int DIM_WIDTH    = mcod_pkg::DEF_DIM_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // Dimension transfers.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mcod_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] dim_value
   input  logic                            req_tlast,  // is_last_dim
   // Table entry transfers.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] row_index, [7:4] col_index, [59:8] min_cost, [63:60] best_split
   output logic [mcod_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [mcod_pkg::STATUS_WIDTH-1:0] rsp_tuser, // [1:0] status
   output logic                            rsp_tlast   // last_result
);
   import mcod_pkg::*;

   localparam int DIM_SLOTS = MAX_MATRICES + 1;
   localparam int IDX_W     = $clog2(DIM_SLOTS);
   localparam int CNT_W     = $clog2(DIM_SLOTS + 1);

   // Dimension store and the combined cost/split table, indexed [i][j].
   logic [DIM_WIDTH-1:0]  dim_mem   [DIM_SLOTS];
   logic [COST_WIDTH-1:0] cost_mem  [DIM_SLOTS][DIM_SLOTS];
   logic [IDX_W-1:0]      split_mem [DIM_SLOTS][DIM_SLOTS];

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [IDX_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        len_ff, len_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [DIM_WIDTH-1:0]    pi_ff, pi_in;
   logic [DIM_WIDTH-1:0]    pj_ff, pj_in;
   logic [COST_WIDTH-1:0]   tmp_ff, tmp_in;
   logic [COST_WIDTH-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]        bestk_ff, bestk_in;
   logic [STATUS_WIDTH-1:0] run_stat_ff, run_stat_in;

   logic                    out_valid_ff, out_valid_in;
   logic [INDEX_WIDTH-1:0]  out_row_ff, out_row_in;
   logic [INDEX_WIDTH-1:0]  out_col_ff, out_col_in;
   logic [COST_WIDTH-1:0]   out_cost_ff, out_cost_in;
   logic [SPLIT_WIDTH-1:0]  out_split_ff, out_split_in;
   logic [STATUS_WIDTH-1:0] out_stat_ff, out_stat_in;
   logic                    out_last_ff, out_last_in;

   // Memory ports.
   logic                  dim_we, dim_re;
   logic [IDX_W-1:0]      dim_waddr, dim_raddr;
   logic [DIM_WIDTH-1:0]  dim_rdata_ff;
   logic                  tab_we, rd_a_en, rd_b_en;
   logic [IDX_W-1:0]      wr_row, wr_col, a_row, a_col, b_row, b_col;
   logic [COST_WIDTH-1:0] wr_cost;
   logic [IDX_W-1:0]      wr_split;
   logic [COST_WIDTH-1:0] cost_a_ff, cost_b_ff;
   logic [IDX_W-1:0]      split_a_ff;

   alu_ctrl_type          alu_ctrl;
   logic [COST_WIDTH-1:0] alu_a, alu_b, alu_res;

   logic                  req_xfer;
   logic                  out_free;
   logic [IDX_W-1:0]      j_w;
   logic                  take_q;
   logic                  k_done;
   logic                  em_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // Right end of the current cell; the cell loop walks by length, then row.
   assign j_w     = IDX_W'(i_ff + len_ff - 1'b1);
   assign take_q  = (k_ff == i_ff) || (alu_res < best_ff);
   assign k_done  = (IDX_W'(k_ff + 1'b1) == j_w);
   assign em_last = (i_ff == n_ff) && (k_ff == n_ff);

   mcod_alu #(
      .DIM_WIDTH (DIM_WIDTH)
   ) u_alu (
      .clock  (clock),
      .ctrl   (alu_ctrl),
      .oper_a (alu_a),
      .oper_b (alu_b),
      .result (alu_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_xfer && req_tlast) state_in = S_START;
         S_START: state_in = (count_ff < CNT_W'(2)) ? S_ERR : S_DIAG;
         S_ERR:   if (out_free) state_in = S_IDLE;
         S_DIAG: begin
            if (i_ff == n_ff) begin
               state_in = (n_ff == IDX_W'(1)) ? S_EM_RD : S_CELL;
            end
         end
         S_CELL:  state_in = S_PI;
         S_PI:    state_in = S_PJ;
         S_PJ:    state_in = S_FETCH;
         S_FETCH: state_in = S_ADD1;
         S_ADD1:  state_in = S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_ADD2;
         S_ADD2:  state_in = S_CMP;
         S_CMP: begin
            if (!k_done) begin
               state_in = S_FETCH;
            end else if (j_w == n_ff && len_ff == n_ff) begin
               state_in = S_EM_RD;
            end else begin
               state_in = S_CELL;
            end
         end
         S_EM_RD: state_in = S_EM_LD;
         S_EM_LD: begin
            if (out_free) state_in = em_last ? S_IDLE : S_EM_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory and arithmetic unit controls.
   always_comb begin
      dim_we    = req_xfer && (count_ff < CNT_W'(DIM_SLOTS));
      dim_waddr = count_ff[IDX_W-1:0];
      dim_re    = 1'b0;
      dim_raddr = k_ff;
      tab_we    = 1'b0;
      wr_row    = i_ff;
      wr_col    = i_ff;
      wr_cost   = '0;
      wr_split  = '0;
      rd_a_en   = 1'b0;
      rd_b_en   = 1'b0;
      a_row     = i_ff;
      a_col     = k_ff;
      b_row     = IDX_W'(k_ff + 1'b1);
      b_col     = j_w;
      alu_ctrl  = '{en: 1'b0, op: ALU_ADD};
      alu_a     = cost_a_ff;
      alu_b     = cost_b_ff;
      case (state_ff)
         S_DIAG: tab_we = 1'b1;
         S_CELL: begin
            dim_re    = 1'b1;
            dim_raddr = IDX_W'(i_ff - 1'b1);
         end
         S_PI: begin
            dim_re    = 1'b1;
            dim_raddr = j_w;
         end
         S_FETCH: begin
            dim_re  = 1'b1;
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         S_ADD1: alu_ctrl = '{en: 1'b1, op: ALU_ADD};
         S_MUL1: begin
            alu_ctrl = '{en: 1'b1, op: ALU_MUL};
            alu_a    = COST_WIDTH'(pi_ff);
            alu_b    = COST_WIDTH'(dim_rdata_ff);
         end
         S_MUL2: begin
            alu_ctrl = '{en: 1'b1, op: ALU_MUL};
            alu_a    = alu_res;
            alu_b    = COST_WIDTH'(pj_ff);
         end
         S_ADD2: begin
            alu_ctrl = '{en: 1'b1, op: ALU_ADD};
            alu_a    = alu_res;
            alu_b    = tmp_ff;
         end
         S_CMP: begin
            tab_we   = k_done;
            wr_col   = j_w;
            wr_cost  = take_q ? alu_res : best_ff;
            wr_split = take_q ? k_ff : bestk_ff;
         end
         S_EM_RD: rd_a_en = 1'b1;
         default: ;
      endcase
   end

   // Datapath and counter updates.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      tmp_in       = tmp_ff;
      best_in      = best_ff;
      bestk_in     = bestk_ff;
      run_stat_in  = run_stat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_cost_in  = out_cost_ff;
      out_split_in = out_split_ff;
      out_stat_in  = out_stat_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // Dimensions past the store's capacity are dropped and flagged.
               if (count_ff < CNT_W'(DIM_SLOTS)) begin
                  count_in = CNT_W'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         S_START: begin
            n_in        = IDX_W'(count_ff - 1'b1);
            run_stat_in = ovf_ff ? STATUS_EXTRA : STATUS_OK;
            i_in        = IDX_W'(1);
         end
         S_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_row_in   = '0;
               out_col_in   = '0;
               out_cost_in  = '0;
               out_split_in = '0;
               out_stat_in  = STATUS_SHORT;
               out_last_in  = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
            end
         end
         S_DIAG: begin
            if (i_ff == n_ff) begin
               i_in   = IDX_W'(1);
               k_in   = IDX_W'(1);
               len_in = IDX_W'(2);
            end else begin
               i_in = IDX_W'(i_ff + 1'b1);
            end
         end
         S_PI: begin
            pi_in = dim_rdata_ff;
            k_in  = i_ff;
         end
         S_PJ:   pj_in  = dim_rdata_ff;
         S_MUL1: tmp_in = alu_res;
         S_CMP: begin
            if (take_q) begin
               best_in  = alu_res;
               bestk_in = k_ff;
            end
            if (!k_done) begin
               k_in = IDX_W'(k_ff + 1'b1);
            end else if (j_w == n_ff) begin
               i_in = IDX_W'(1);
               if (len_ff == n_ff) begin
                  k_in = IDX_W'(1);
               end else begin
                  len_in = IDX_W'(len_ff + 1'b1);
               end
            end else begin
               i_in = IDX_W'(i_ff + 1'b1);
            end
         end
         S_EM_LD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_row_in   = INDEX_WIDTH'(i_ff);
               out_col_in   = INDEX_WIDTH'(k_ff);
               out_cost_in  = cost_a_ff;
               out_split_in = SPLIT_WIDTH'(split_a_ff);
               out_stat_in  = run_stat_ff;
               out_last_in  = em_last;
               if (em_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else if (k_ff == n_ff) begin
                  i_in = IDX_W'(i_ff + 1'b1);
                  k_in = IDX_W'(i_ff + 1'b1);
               end else begin
                  k_in = IDX_W'(k_ff + 1'b1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      len_ff       <= len_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      pi_ff        <= pi_in;
      pj_ff        <= pj_in;
      tmp_ff       <= tmp_in;
      best_ff      <= best_in;
      bestk_ff     <= bestk_in;
      run_stat_ff  <= run_stat_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_cost_ff  <= out_cost_in;
      out_split_ff <= out_split_in;
      out_stat_ff  <= out_stat_in;
      out_last_ff  <= out_last_in;
   end

   // Dimension store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (dim_we) begin
         dim_mem[dim_waddr] <= req_tdata[DIM_WIDTH-1:0];
      end
      if (dim_re) begin
         dim_rdata_ff <= dim_mem[dim_raddr];
      end
   end

   // Cost and split table: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         cost_mem[wr_row][wr_col]  <= wr_cost;
         split_mem[wr_row][wr_col] <= wr_split;
      end
      if (rd_a_en) begin
         cost_a_ff  <= cost_mem[a_row][a_col];
         split_a_ff <= split_mem[a_row][a_col];
      end
      if (rd_b_en) begin
         cost_b_ff <= cost_mem[b_row][b_col];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_split_ff, out_cost_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: verif/matrix_chain_order_dp_test.sv
// Self-checking testbench for the matrix chain order block with a table-entry scoreboard.
`timescale 1ns / 1ps

module matrix_chain_order_dp_test;

   // Nine dimension slots describe a chain of up to eight matrices.
   localparam int MAX_DIMS     = mcod_pkg::DEF_MAX_MATRICES + 1;
   localparam int ITEM_TARGET  = 430;
   localparam int HOLD_CHAIN   = 8;
   localparam int DRAIN_CHAIN  = 40;
   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 40;

   localparam logic [63:0] COST_CAP =
      {{(64 - mcod_pkg::COST_WIDTH){1'b0}}, mcod_pkg::COST_MAX};

   logic clock;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [mcod_pkg::REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                                req_tlast  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [mcod_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [mcod_pkg::STATUS_WIDTH-1:0]   rsp_tuser;
   logic                                rsp_tlast;

   // Idling mode: 0 = sender idles lightly and receiver heavily, 1 = the
   // reverse, 2 = neither side idles.
   int idle_mode = 0;

   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_request = 1'b0;

   // One expected table entry, in the order the block emits them.
   typedef struct {
      logic [mcod_pkg::INDEX_WIDTH-1:0]  row;
      logic [mcod_pkg::INDEX_WIDTH-1:0]  col;
      logic [mcod_pkg::COST_WIDTH-1:0]   cost;
      logic [mcod_pkg::SPLIT_WIDTH-1:0]  split;
      logic [mcod_pkg::STATUS_WIDTH-1:0] status;
      logic                              last;
   } table_entry_type;

   // The scoreboard collects the dimensions of the current chain. When the
   // final dimension arrives it solves the chain by interval dynamic
   // programming and queues the whole upper triangle, row by row.
   class chain_table_scoreboard;
      logic [15:0]  dims [MAX_DIMS];
      int unsigned  held;
      bit           extra;
      table_entry_type pending_entries [$];
      int unsigned  checked;
      int unsigned  errors;

      function new();
         held   = 0;
         extra  = 1'b0;
         checked = 0;
         errors = 0;
      endfunction

      function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
         if (a >= COST_CAP || b >= COST_CAP || a > COST_CAP - b) return COST_CAP;
         return a + b;
      endfunction

      function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
         if (a == 0 || b == 0) return 64'd0;
         if (a > COST_CAP / b) return COST_CAP;
         return a * b;
      endfunction

      function void solve_chain();
         logic [63:0] cost [MAX_DIMS][MAX_DIMS];
         int          split [MAX_DIMS][MAX_DIMS];
         logic [63:0] best;
         logic [63:0] prod;
         logic [63:0] q;
         logic [mcod_pkg::STATUS_WIDTH-1:0] st;
         int          n;
         int          best_k;
         int          j;
         table_entry_type e;
         if (held < 2) begin
            // Too short a list: a single error entry with zero fields.
            e.row    = '0;
            e.col    = '0;
            e.cost   = '0;
            e.split  = '0;
            e.status = mcod_pkg::STATUS_SHORT;
            e.last   = 1'b1;
            pending_entries.push_back(e);
         end else begin
            n  = held - 1;
            st = extra ? mcod_pkg::STATUS_EXTRA : mcod_pkg::STATUS_OK;
            for (int i = 1; i <= n; i++) begin
               cost[i][i]  = 64'd0;
               split[i][i] = 0;
            end
            for (int span = 2; span <= n; span++) begin
               for (int i = 1; i + span - 1 <= n; i++) begin
                  j      = i + span - 1;
                  best   = 64'd0;
                  best_k = i;
                  for (int k = i; k < j; k++) begin
                     prod = sat_mul(sat_mul(64'(dims[i-1]), 64'(dims[k])), 64'(dims[j]));
                     q    = sat_add(sat_add(cost[i][k], cost[k+1][j]), prod);
                     // Strict compare keeps the smallest split on a tie.
                     if (k == i || q < best) begin
                        best   = q;
                        best_k = k;
                     end
                  end
                  cost[i][j]  = best;
                  split[i][j] = best_k;
               end
            end
            for (int i = 1; i <= n; i++) begin
               for (int c = i; c <= n; c++) begin
                  e.row    = 4'(i);
                  e.col    = 4'(c);
                  e.cost   = cost[i][c][mcod_pkg::COST_WIDTH-1:0];
                  e.split  = 4'(split[i][c]);
                  e.status = st;
                  e.last   = (i == n && c == n);
                  pending_entries.push_back(e);
               end
            end
         end
         held  = 0;
         extra = 1'b0;
      endfunction

      function void note_dimension(logic [15:0] dim, logic final_dim);
         if (held < MAX_DIMS) begin
            dims[held] = dim;
            held++;
         end else begin
            extra = 1'b1;
         end
         if (final_dim) solve_chain();
      endfunction

      function int pending();
         return pending_entries.size();
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t: mismatch on table entry %0d: %s got 0x%0h expected 0x%0h",
                     $time, checked, what, got, want);
      endtask

      task check_entry(logic [mcod_pkg::RSP_DATA_W-1:0] data,
                       logic [mcod_pkg::STATUS_WIDTH-1:0] user, logic last_flag);
         table_entry_type want;
         checked++;
         if (pending_entries.size() == 0) begin
            report("entry with nothing expected", 64'(data), 64'd0);
            return;
         end
         want = pending_entries.pop_front();
         if (data[3:0] !== want.row)    report("row_index", 64'(data[3:0]), 64'(want.row));
         if (data[7:4] !== want.col)    report("col_index", 64'(data[7:4]), 64'(want.col));
         if (data[59:8] !== want.cost)  report("min_cost", 64'(data[59:8]), 64'(want.cost));
         if (data[63:60] !== want.split)
            report("best_split", 64'(data[63:60]), 64'(want.split));
         if (user !== want.status)      report("status", 64'(user), 64'(want.status));
         if (last_flag !== want.last)   report("last_result", 64'(last_flag), 64'(want.last));
      endtask
   endclass

   chain_table_scoreboard sb;

   matrix_chain_order_dp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one dimension, with random idle cycles ahead of it, and holds it
   // until the block takes the transfer. Valid stays high afterwards so that
   // back-to-back transfers need no gap.
   task automatic send_dim(logic [15:0] dim, logic final_dim);
      while ($urandom_range(0, 99) < (idle_mode == 0 ? 20 : (idle_mode == 1 ? 71 : 0))) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dim;
      req_tlast  <= final_dim;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_dimension(dim, final_dim);
   endtask

   task automatic send_chain(logic [15:0] vals [$]);
      foreach (vals[x]) send_dim(vals[x], x == vals.size() - 1);
   endtask

   // Drops valid, then waits until every queued
   // table entry has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Receiver: checks each accepted entry, then picks the ready for the
   // next cycle. A requested hold-off keeps ready low for a long stretch so
   // that the block backs up and stalls its input side.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tready && rsp_tvalid !== 1'b0)
            sb.check_entry(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >=
                           (idle_mode == 0 ? 71 : (idle_mode == 1 ? 20 : 0)));
         end
      end
   end

   // Watchdog: a correct run finishes far below this count.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("matrix_chain_order_dp_test NOT OK");
      $finish;
   end

   // Main stimulus.
   initial begin
      logic [15:0] chain [$];
      logic [15:0] v;
      int fed;
      int len;
      int style;
      int r;
      int chains_done;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed chains. A lone dimension is too short and must give the
      // error entry.
      chain = '{16'hFFFF};
      send_chain(chain);
      // A single matrix, with both dimension extremes.
      chain = '{16'h0000, 16'hFFFF};
      send_chain(chain);
      // Equal dimensions make every split cost the same, so the first wins.
      chain = '{16'd2, 16'd2, 16'd2, 16'd2};
      send_chain(chain);
      // Full capacity with the largest dimensions gives the largest costs.
      chain.delete();
      repeat (MAX_DIMS) chain.push_back(16'hFFFF);
      send_chain(chain);
      // One dimension past capacity: it is dropped and the run is flagged.
      // The zero dimension yields zero products inside the chain.
      chain = '{16'd7, 16'd0, 16'd13, 16'h8000, 16'h7FFF, 16'd1, 16'd40, 16'd3,
                16'd9, 16'd55};
      send_chain(chain);
      wait_drained();

      // Random chains: mostly well-formed lists of varied length, with some
      // too-short and some over-long lists mixed in.
      fed = 0;
      chains_done = 0;
      while (fed < ITEM_TARGET) begin
         idle_mode = fed * 3 / ITEM_TARGET;
         r = $urandom_range(0, 99);
         if (chains_done == HOLD_CHAIN) len = MAX_DIMS;
         else if (r < 6) len = 1;
         else if (r < 14) len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 3);
         else if (r < 40) len = MAX_DIMS;
         else len = $urandom_range(2, MAX_DIMS - 1);
         style = $urandom_range(0, 3);
         chain.delete();
         for (int x = 0; x < len; x++) begin
            case (style)
               0: v = 16'($urandom_range(1, 40));
               1: v = 16'($urandom_range(0, 65535));
               // Tiny values give many cost ties.
               2: v = 16'($urandom_range(1, 3));
               default: begin
                  case ($urandom_range(0, 3))
                     0: v = 16'h0000;
                     1: v = 16'hFFFF;
                     2: v = 16'h0001;
                     default: v = 16'($urandom_range(0, 65535));
                  endcase
               end
            endcase
            chain.push_back(v);
         end
         send_chain(chain);
         fed += (len > MAX_DIMS) ? MAX_DIMS : len;
         chains_done++;
         // Right after a full chain starts its run, stall the receiver for a
         // long time while the next chain is already being offered.
         if (chains_done == HOLD_CHAIN + 1) hold_request = 1'b1;
         // Once in the middle, let everything drain before going on.
         if (chains_done == DRAIN_CHAIN) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("matrix_chain_order_dp_test OK");
      end else begin
         $display("matrix_chain_order_dp_test NOT OK");
      end
      $finish;
   end

endmodule
